FILE: sv/sfbd_pkg.sv
// Shared types, codes and constants of the firmware frame deframer.
package sfbd_pkg;

  localparam int DATA_BYTES_DEF   = 32;
  localparam int SECTOR_BYTES_DEF = 512;

  localparam logic [7:0]  SOF_BYTE      = 8'hF0;
  localparam logic [7:0]  ID0_BYTE      = 8'h00;
  localparam logic [7:0]  ID1_BYTE      = 8'h7F;
  localparam logic [7:0]  EOF_BYTE      = 8'hF7;
  localparam logic [7:0]  TOP_BIT_MASK  = 8'h80;
  localparam logic [6:0]  SEQ_MAX       = 7'd127;
  localparam logic [6:0]  SEQ_FIRST     = 7'd1;
  localparam logic [15:0] BASE_ADDR_RST = 16'hA000;
  localparam logic [6:0]  PRODUCT_RST   = 7'h21;
  localparam logic [15:0] BLOCK_STRIDE  = 16'd8;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_PRODUCT_CODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ERASE   = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_LINE     = 3'd0,
    ERR_FRAMING  = 3'd1,
    ERR_IDENTITY = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_SEQUENCE = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_CHECK,
    ST_LOAD,
    ST_ERASE,
    ST_PROG,
    ST_HALT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  take_byte;
    logic  seq_update;
    logic  load_start;
    logic  load_step;
    logic  adv_block;
    logic  emit;
    kind_t kind;
    err_t  code;
    logic  last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_byte;
    logic frame_ok;
    logic id_ok;
    logic csum_ok;
    logic seq_zero;
    logic seq_ok;
    logic sector_start;
    logic block_last;
    logic load_done;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/sysex_firmware_block_deframer_top.sv
// Top level of the firmware frame deframer: ports, controller and datapath.
//
// Collects fixed frames of received serial bytes (start, two ID bytes, product,
// sequence, DATA_BYTES data bytes, packed top bits, XOR checksum, end) and turns
// each good frame into flash commands: per eight data bytes an optional sector
// erase (when the running address sits on a SECTOR_BYTES boundary) followed by
// a program command carrying the eight restored bytes. Frame checks run in the
// order framing, identity/product, checksum, sequence; sequence 0 ends the
// download. Any error, a line error on a received word, or end of data halts
// the block until reset; while halted input words are taken and dropped.
// Flow: a received byte is taken while the result register is free. At frame
// end the check state decides the checks, then each block of eight bytes is
// read out (eight registered reads of the data store, a shift of the last
// byte, a hand-over) and followed by an optional erase and a program command,
// each waiting for the result register to drain.
// Writing base_address also restarts the running address there.
module sysex_firmware_block_deframer_top #(
  parameter int DATA_BYTES   = sfbd_pkg::DATA_BYTES_DEF,
  parameter int SECTOR_BYTES = sfbd_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] line_error
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [15:0] flash_address, [79:16] program_data,
                                 // [82:80] error_code, [87:83] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last_of_frame
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  sfbd_pkg::cmd_t cmd;
  sfbd_pkg::sts_t sts;
  logic [15:0]    out_addr;
  logic [63:0]    out_data;
  logic [2:0]     out_code;

  sfbd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .line_error (s_tuser),
    .sts        (sts),
    .cmd        (cmd)
  );

  sfbd_datapath #(
    .DATA_BYTES   (DATA_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .out_kind  (m_tuser),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_code  (out_code),
    .out_last  (m_tlast)
  );

  // pack result word, first field lowest, padded to whole bytes
  assign m_tdata = {5'b00000, out_code, out_data, out_addr};

endmodule

FILE: sv/sfbd_ctrl.sv
// Sequencing state machine of the firmware frame deframer.
module sfbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            line_error,
  input  sfbd_pkg::sts_t  sts,
  output sfbd_pkg::cmd_t  cmd
);

  sfbd_pkg::state_t state;
  sfbd_pkg::state_t state_next;
  logic             in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfbd_pkg::ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = ((state == sfbd_pkg::ST_RECV) && sts.out_free) ||
                    (state == sfbd_pkg::ST_HALT);
  assign in_take  = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = sfbd_pkg::KIND_ERROR;
    cmd.code   = sfbd_pkg::ERR_LINE;
    unique case (state)
      sfbd_pkg::ST_RECV: begin
        if (in_take) begin
          if (line_error) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            state_next = sfbd_pkg::ST_HALT;
          end else begin
            cmd.take_byte = 1'b1;
            if (sts.last_byte) begin
              state_next = sfbd_pkg::ST_CHECK;
            end
          end
        end
      end
      sfbd_pkg::ST_CHECK: begin
        if (sts.out_free) begin
          cmd.last = 1'b1;
          priority if (!sts.frame_ok) begin
            cmd.emit   = 1'b1;
            cmd.code   = sfbd_pkg::ERR_FRAMING;
            state_next = sfbd_pkg::ST_HALT;
          end else if (!sts.id_ok) begin
            cmd.emit   = 1'b1;
            cmd.code   = sfbd_pkg::ERR_IDENTITY;
            state_next = sfbd_pkg::ST_HALT;
          end else if (!sts.csum_ok) begin
            cmd.emit   = 1'b1;
            cmd.code   = sfbd_pkg::ERR_CHECKSUM;
            state_next = sfbd_pkg::ST_HALT;
          end else if (sts.seq_zero) begin
            cmd.emit   = 1'b1;
            cmd.kind   = sfbd_pkg::KIND_DONE;
            state_next = sfbd_pkg::ST_HALT;
          end else begin
            cmd.seq_update = 1'b1;
            if (!sts.seq_ok) begin
              cmd.emit   = 1'b1;
              cmd.code   = sfbd_pkg::ERR_SEQUENCE;
              state_next = sfbd_pkg::ST_HALT;
            end else begin
              cmd.last       = 1'b0;
              cmd.load_start = 1'b1;
              state_next     = sfbd_pkg::ST_LOAD;
            end
          end
        end
      end
      sfbd_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (sts.load_done) begin
          state_next = sts.sector_start ? sfbd_pkg::ST_ERASE : sfbd_pkg::ST_PROG;
        end
      end
      sfbd_pkg::ST_ERASE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = sfbd_pkg::KIND_ERASE;
          state_next = sfbd_pkg::ST_PROG;
        end
      end
      sfbd_pkg::ST_PROG: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = sfbd_pkg::KIND_PROGRAM;
          cmd.last      = sts.block_last;
          cmd.adv_block = 1'b1;
          if (sts.block_last) begin
            state_next = sfbd_pkg::ST_RECV;
          end else begin
            cmd.load_start = 1'b1;
            state_next     = sfbd_pkg::ST_LOAD;
          end
        end
      end
      sfbd_pkg::ST_HALT: begin
        // drop every word until reset
      end
      default: begin
        state_next = sfbd_pkg::ST_HALT;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result issued while output register busy");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (state == sfbd_pkg::ST_HALT) |=> (state == sfbd_pkg::ST_HALT))
    else $error("left halt without reset");

  a_take_recv: assert property (@(posedge clk) disable iff (rst)
    cmd.take_byte |-> (state == sfbd_pkg::ST_RECV) && s_tvalid && !line_error)
    else $error("byte stored outside collection");

  a_seq_once: assert property (@(posedge clk) disable iff (rst)
    cmd.seq_update |=> !cmd.seq_update)
    else $error("sequence advanced twice for one frame");

endmodule

FILE: sv/sfbd_datapath.sv
// Frame store, checks, data restore, address counter and result register.
module sfbd_datapath #(
  parameter int DATA_BYTES   = sfbd_pkg::DATA_BYTES_DEF,
  parameter int SECTOR_BYTES = sfbd_pkg::SECTOR_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  sfbd_pkg::cmd_t  cmd,
  output sfbd_pkg::sts_t  sts,
  input  logic            m_tready,
  output logic            m_tvalid,
  output logic [1:0]      out_kind,
  output logic [15:0]     out_addr,
  output logic [63:0]     out_data,
  output logic [2:0]      out_code,
  output logic            out_last
);

  localparam int TOP_BYTES = (DATA_BYTES + 6) / 7;
  localparam int TOP_BITS  = TOP_BYTES * 7;
  localparam int POS_SEQ   = 4;
  localparam int POS_DATA  = 5;
  localparam int POS_TOP   = POS_DATA + DATA_BYTES;
  localparam int POS_CSUM  = POS_TOP + TOP_BYTES;
  localparam int POS_END   = POS_CSUM + 1;
  localparam int FRAME_LEN = POS_END + 1;
  localparam int BLOCKS    = DATA_BYTES / 8;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int DI_W      = $clog2(DATA_BYTES);
  localparam int TB_W      = $clog2(TOP_BITS);
  localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  logic [POS_W-1:0]    pos;
  logic                sof_ok, id0_ok, id1_ok, eof_ok;
  logic [7:0]          prod_byte, seq_byte, csum_byte, csum;
  logic [TOP_BITS-1:0] topbits;
  logic [6:0]          exp_seq;
  logic [6:0]          product_code;
  logic [15:0]         write_address;
  logic [6:0]          seq_next;

  logic [7:0]          mem [DATA_BYTES];
  logic [7:0]          rd_data;
  logic                mem_we;
  logic [DI_W-1:0]     mem_wa;
  logic [DI_W-1:0]     rd_ptr, rd_idx;
  logic                rd_v;
  logic [3:0]          ld_cnt;
  logic                rd_issue;
  logic [7:0]          restored;
  logic [63:0]         prog_word;
  logic [BLK_W-1:0]    blk;

  // collection side
  assign mem_we = cmd.take_byte && (pos >= POS_W'(POS_DATA)) && (pos < POS_W'(POS_TOP));
  assign mem_wa = DI_W'(pos - POS_W'(POS_DATA));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.take_byte) begin
      pos <= (pos == POS_W'(FRAME_LEN - 1)) ? '0 : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (pos == '0)                  sof_ok    <= (rx_byte == sfbd_pkg::SOF_BYTE);
      if (pos == POS_W'(1))           id0_ok    <= (rx_byte == sfbd_pkg::ID0_BYTE);
      if (pos == POS_W'(2))           id1_ok    <= (rx_byte == sfbd_pkg::ID1_BYTE);
      if (pos == POS_W'(3))           prod_byte <= rx_byte;
      if (pos == POS_W'(POS_SEQ))     seq_byte  <= rx_byte;
      if (pos == POS_W'(POS_CSUM))    csum_byte <= rx_byte;
      if (pos == POS_W'(POS_END))     eof_ok    <= (rx_byte == sfbd_pkg::EOF_BYTE);
      if (pos == POS_W'(POS_SEQ)) begin
        csum <= rx_byte;
      end else if ((pos > POS_W'(POS_SEQ)) && (pos < POS_W'(POS_CSUM))) begin
        csum <= csum ^ rx_byte;
      end
      for (int i = 0; i < TOP_BYTES; i++) begin
        if (pos == POS_W'(POS_TOP + i)) topbits[i*7 +: 7] <= rx_byte[6:0];
      end
    end
  end

  // data store: one write port for collection, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= rx_byte;
    if (rd_issue) rd_data <= mem[rd_ptr];
  end

  // configuration and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      product_code  <= sfbd_pkg::PRODUCT_RST;
      write_address <= sfbd_pkg::BASE_ADDR_RST;
      exp_seq       <= '0;
    end else begin
      if (cfg_we && (cfg_index == sfbd_pkg::CFG_BASE_ADDRESS)) begin
        write_address <= cfg_data;
      end
      if (cfg_we && (cfg_index == sfbd_pkg::CFG_PRODUCT_CODE)) begin
        product_code <= cfg_data[6:0];
      end
      if (cmd.adv_block) write_address <= write_address + sfbd_pkg::BLOCK_STRIDE;
      if (cmd.seq_update) exp_seq <= seq_next;
    end
  end

  assign seq_next = (exp_seq == sfbd_pkg::SEQ_MAX) ? sfbd_pkg::SEQ_FIRST
                                                   : exp_seq + 7'd1;

  // block assembly: eight registered reads, each byte then shifted into the program word
  assign rd_issue = cmd.load_step && (ld_cnt != 4'd8);
  assign restored = rd_data | (topbits[TB_W'(rd_idx)] ? sfbd_pkg::TOP_BIT_MASK : 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      ld_cnt <= '0;
    end else begin
      rd_v <= rd_issue;
      if (cmd.load_start) begin
        ld_cnt <= '0;
      end else if (rd_issue) begin
        ld_cnt <= ld_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_update) begin
      rd_ptr <= '0;
      blk    <= '0;
    end else begin
      if (rd_issue) rd_ptr <= rd_ptr + DI_W'(1);
      if (cmd.adv_block) blk <= blk + BLK_W'(1);
    end
    if (rd_issue) rd_idx <= rd_ptr;
    if (rd_v) prog_word <= {restored, prog_word[63:8]};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_last <= cmd.last;
      out_addr <= ((cmd.kind == sfbd_pkg::KIND_ERASE) ||
                   (cmd.kind == sfbd_pkg::KIND_PROGRAM)) ? write_address : 16'h0000;
      out_data <= (cmd.kind == sfbd_pkg::KIND_PROGRAM) ? prog_word : 64'h0;
      out_code <= (cmd.kind == sfbd_pkg::KIND_ERROR) ? cmd.code : 3'd0;
    end
  end

  always_comb begin
    sts.last_byte    = (pos == POS_W'(FRAME_LEN - 1));
    sts.frame_ok     = sof_ok && eof_ok;
    sts.id_ok        = id0_ok && id1_ok && (prod_byte == {1'b0, product_code});
    sts.csum_ok      = (csum == csum_byte);
    sts.seq_zero     = (seq_byte == 8'h00);
    sts.seq_ok       = (seq_byte == {1'b0, seq_next});
    sts.sector_start = ((write_address & 16'(SECTOR_BYTES - 1)) == 16'h0000);
    sts.block_last   = (blk == BLK_W'(BLOCKS - 1));
    sts.load_done    = (ld_cnt == 4'd8) && !rd_v;
    sts.out_free     = !m_tvalid || m_tready;
  end

endmodule

FILE: test/sysex_firmware_block_deframer_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the firmware frame deframer top level.
module sysex_firmware_block_deframer_top_test;

  // Frame layout, derived the same way the block sizes its store.
  localparam int DATA_BYTES   = sfbd_pkg::DATA_BYTES_DEF;
  localparam int SECTOR_BYTES = sfbd_pkg::SECTOR_BYTES_DEF;
  localparam int TOP_BYTES    = (DATA_BYTES + 6) / 7;
  localparam int POS_SEQ      = 4;
  localparam int POS_DATA     = 5;
  localparam int POS_TOP      = POS_DATA + DATA_BYTES;
  localparam int POS_CSUM     = POS_TOP + TOP_BYTES;
  localparam int POS_END      = POS_CSUM + 1;
  localparam int FRAME_LEN    = POS_END + 1;
  localparam int BLOCKS       = DATA_BYTES / 8;

  // Worst case: 464 words and at most 46 commands, each behind the longest gap
  // on both sides, plus frame processing and settle time, stays well under
  // CYCLE_LIMIT.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PRINT_LIMIT   = 30;

  // error_code reads zero on every result that is not an error.
  localparam sfbd_pkg::err_t NO_ERR = sfbd_pkg::ERR_LINE;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RANDOM} fill_t;
  typedef enum int {
    END_LINE, END_FRAMING, END_IDENTITY, END_CHECKSUM, END_SEQUENCE, END_DONE
  } ending_t;

  typedef struct packed {
    sfbd_pkg::kind_t kind;
    logic [15:0]     addr;
    logic [63:0]     data;
    sfbd_pkg::err_t  code;
    logic            last;
  } flash_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = sfbd_pkg::CFG_BASE_ADDRESS;
  logic [15:0] cfg_data = 16'h0000;

  sysex_firmware_block_deframer_top #(
    .DATA_BYTES  (DATA_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Deframer model state: its own copy of the store, counters and registers.
  logic [7:0]  rx_frame [FRAME_LEN];
  int          rx_pos;
  logic [6:0]  last_seq;
  logic [15:0] prog_addr;
  logic        stopped;
  logic [6:0]  product_reg;
  flash_cmd_t  flash_cmds_due [$];

  // Stimulus state.
  logic [7:0]  payload [DATA_BYTES];
  logic [7:0]  tx_frame [FRAME_LEN];
  logic [6:0]  tx_seq = sfbd_pkg::SEQ_FIRST;
  ending_t     ending = END_DONE;
  logic        steady = 1'b0;
  int          stall_left = 0;

  // Bookkeeping.
  int          mismatches = 0;
  int          cmds_checked = 0;
  int          words_sent = 0;
  int          frames_sent = 0;
  int          wraps = 0;
  int          cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop if the block hangs anywhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d commands still due", cycle_count,
               flash_cmds_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all during a steady stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall at random, and now and then flip into or out of a
  // steady stretch that both sides honor.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) steady = !steady;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------
  task automatic reset_model();
    foreach (rx_frame[i]) rx_frame[i] = 8'h00;
    rx_pos      = 0;
    last_seq    = 7'd0;
    product_reg = sfbd_pkg::PRODUCT_RST;
    prog_addr   = sfbd_pkg::BASE_ADDR_RST;
    stopped     = 1'b0;
  endtask

  task automatic push_cmd(input sfbd_pkg::kind_t k, input logic [15:0] a,
                          input logic [63:0] d, input sfbd_pkg::err_t c,
                          input logic l);
    flash_cmd_t cmd;
    cmd.kind = k;
    cmd.addr = a;
    cmd.data = d;
    cmd.code = c;
    cmd.last = l;
    flash_cmds_due.push_back(cmd);
  endtask

  // Any error halts the block for good with a single error command.
  task automatic halt_with(input sfbd_pkg::err_t c);
    stopped = 1'b1;
    push_cmd(sfbd_pkg::KIND_ERROR, 16'h0000, 64'h0, c, 1'b1);
  endtask

  // Take one accepted word and queue the flash commands it causes.
  task automatic deframe_word(input logic [7:0] b, input logic line_err);
    logic [7:0]  sum;
    logic [7:0]  restored;
    logic [6:0]  nxt;
    logic [63:0] blk;
    int          idx;
    if (stopped) return;
    if (line_err) begin
      halt_with(sfbd_pkg::ERR_LINE);
      return;
    end
    rx_frame[rx_pos] = b;
    rx_pos++;
    if (rx_pos < FRAME_LEN) return;
    rx_pos = 0;

    // Checks in priority order: framing, identity, checksum, sequence.
    if (rx_frame[0] != sfbd_pkg::SOF_BYTE || rx_frame[POS_END] != sfbd_pkg::EOF_BYTE) begin
      halt_with(sfbd_pkg::ERR_FRAMING);
      return;
    end
    if (rx_frame[1] != sfbd_pkg::ID0_BYTE || rx_frame[2] != sfbd_pkg::ID1_BYTE ||
        rx_frame[3] != {1'b0, product_reg}) begin
      halt_with(sfbd_pkg::ERR_IDENTITY);
      return;
    end
    sum = 8'h00;
    for (int i = POS_SEQ; i < POS_CSUM; i++) sum ^= rx_frame[i];
    if (sum != rx_frame[POS_CSUM]) begin
      halt_with(sfbd_pkg::ERR_CHECKSUM);
      return;
    end
    if (rx_frame[POS_SEQ] == 8'h00) begin
      stopped = 1'b1;
      push_cmd(sfbd_pkg::KIND_DONE, 16'h0000, 64'h0, NO_ERR, 1'b1);
      return;
    end
    // The expected count advances even when the frame then fails on it.
    nxt = (last_seq == sfbd_pkg::SEQ_MAX) ? sfbd_pkg::SEQ_FIRST : last_seq + 7'd1;
    last_seq = nxt;
    if (rx_frame[POS_SEQ] != {1'b0, nxt}) begin
      halt_with(sfbd_pkg::ERR_SEQUENCE);
      return;
    end

    for (int i = 0; i < BLOCKS; i++) begin
      if (int'(prog_addr) % SECTOR_BYTES == 0)
        push_cmd(sfbd_pkg::KIND_ERASE, prog_addr, 64'h0, NO_ERR, 1'b0);
      blk = 64'h0;
      for (int j = 7; j >= 0; j--) begin
        idx = i * 8 + j;
        restored = rx_frame[POS_DATA + idx];
        if (rx_frame[POS_TOP + idx / 7][idx % 7]) restored |= sfbd_pkg::TOP_BIT_MASK;
        blk = {blk[55:0], restored};
      end
      push_cmd(sfbd_pkg::KIND_PROGRAM, prog_addr, blk, NO_ERR, i == BLOCKS - 1);
      prog_addr = prog_addr + sfbd_pkg::BLOCK_STRIDE;
    end
  endtask

  // Compare every command the block hands over against the oldest one due.
  always @(posedge clk) begin : cmd_check
    flash_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (flash_cmds_due.size() == 0) begin
        report_mismatch("unexpected command, kind", 64'(m_tuser), 64'h0);
      end else begin
        want = flash_cmds_due.pop_front();
        cmds_checked++;
        if (m_tuser != want.kind)
          report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[15:0] != want.addr)
          report_mismatch("flash_address", 64'(m_tdata[15:0]), 64'(want.addr));
        if (m_tdata[79:16] != want.data)
          report_mismatch("program_data", m_tdata[79:16], want.data);
        if (m_tdata[82:80] != want.code)
          report_mismatch("error_code", 64'(m_tdata[82:80]), 64'(want.code));
        if (m_tdata[87:83] != 5'd0)
          report_mismatch("tdata pad", 64'(m_tdata[87:83]), 64'h0);
        if (m_tlast != want.last)
          report_mismatch("last_of_frame", 64'(m_tlast), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one word; hold tvalid across back-to-back words, drop it for a gap.
  task automatic send_word(input logic [7:0] b, input logic line_err);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= line_err;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    deframe_word(b, line_err);
  endtask

  // Drop tvalid, let every due command arrive, then let the block settle.
  task automatic wait_idle();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (flash_cmds_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (flash_cmds_due.size() != 0) begin
      report_mismatch("commands never issued", 64'(flash_cmds_due.size()), 64'h0);
      flash_cmds_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register; only called while the block is idle.
  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfbd_pkg::CFG_BASE_ADDRESS) begin
      prog_addr = val;
    end else begin
      product_reg = val[6:0];
    end
  endtask

  // Move the running address somewhere new or change the product code.
  task automatic retarget();
    logic [15:0] a;
    a = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0: cfg_write(sfbd_pkg::CFG_BASE_ADDRESS, a);
      1: begin
        a[8:0] = 9'h1F0;   // two blocks short of a sector boundary
        cfg_write(sfbd_pkg::CFG_BASE_ADDRESS, a);
      end
      default: cfg_write(sfbd_pkg::CFG_PRODUCT_CODE, 16'($urandom_range(0, 65535)));
    endcase
  endtask

  task automatic seal_frame();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = POS_SEQ; i < POS_CSUM; i++) sum ^= tx_frame[i];
    tx_frame[POS_CSUM] = sum;
  endtask

  // Pack payload into a frame. With junk set, bit 7 of data bytes (kept and
  // ORed with its top bit) and bits the block must not care about (bit 7 of
  // top-bit bytes, unused top-bit positions) are randomized.
  task automatic build_frame(input fill_t fill, input logic [7:0] seq_byte,
                             input logic junk);
    foreach (payload[k]) begin
      case (fill)
        FILL_ZERO: payload[k] = 8'h00;
        FILL_ONES: payload[k] = 8'hFF;
        FILL_RAMP: payload[k] = 8'(k * 37 + 5);
        default:   payload[k] = 8'($urandom_range(0, 255));
      endcase
    end
    tx_frame[0]       = sfbd_pkg::SOF_BYTE;
    tx_frame[1]       = sfbd_pkg::ID0_BYTE;
    tx_frame[2]       = sfbd_pkg::ID1_BYTE;
    tx_frame[3]       = {1'b0, product_reg};
    tx_frame[POS_SEQ] = seq_byte;
    for (int t = 0; t < TOP_BYTES; t++) begin
      for (int p = 0; p < 8; p++)
        tx_frame[POS_TOP + t][p] = (junk && (p == 7 || t * 7 + p >= DATA_BYTES)) ?
                                   1'($urandom_range(0, 1)) : 1'b0;
    end
    for (int k = 0; k < DATA_BYTES; k++) begin
      tx_frame[POS_DATA + k] = {junk ? 1'($urandom_range(0, 1)) : 1'b0, payload[k][6:0]};
      tx_frame[POS_TOP + k / 7][k % 7] = payload[k][7];
    end
    tx_frame[POS_END] = sfbd_pkg::EOF_BYTE;
    seal_frame();
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_LEN; i++) send_word(tx_frame[i], 1'b0);
    frames_sent++;
  endtask

  // One well-formed frame carrying the next sequence number.
  task automatic good_frame(input fill_t fill, input logic junk);
    build_frame(fill, {1'b0, tx_seq}, junk);
    send_frame();
    if (tx_seq == sfbd_pkg::SEQ_MAX) begin
      tx_seq = sfbd_pkg::SEQ_FIRST;
      wraps++;
    end else begin
      tx_seq = tx_seq + 7'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: start at the default address, which opens a sector.
  task automatic test_default_setup();
    good_frame(FILL_ZERO, 1'b0);
    good_frame(FILL_ONES, 1'b0);
    wait_idle();
  endtask

  // Register extremes, address wrap at the top of memory, and a product write
  // that must leave the running address alone.
  task automatic test_config_extremes();
    cfg_write(sfbd_pkg::CFG_PRODUCT_CODE, 16'h0000);
    cfg_write(sfbd_pkg::CFG_BASE_ADDRESS, 16'hFFF8);
    good_frame(FILL_RAMP, 1'b1);
    wait_idle();
    cfg_write(sfbd_pkg::CFG_PRODUCT_CODE, 16'hFFFF);
    cfg_write(sfbd_pkg::CFG_BASE_ADDRESS, 16'hFFFF);
    good_frame(FILL_RANDOM, 1'b1);
    wait_idle();
    cfg_write(sfbd_pkg::CFG_BASE_ADDRESS, 16'h0000);
    good_frame(FILL_ONES, 1'b1);
    wait_idle();
    cfg_write(sfbd_pkg::CFG_PRODUCT_CODE, {9'h000, sfbd_pkg::PRODUCT_RST});
    good_frame(FILL_RANDOM, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    repeat (3) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        retarget();
      end
      good_frame(FILL_RANDOM, 1'($urandom_range(0, 1)));
    end
    wait_idle();
  endtask

  // Close the download one way or another, then show that a halted block
  // swallows everything silently. Lower-priority faults ride along at random
  // to check the order of the frame checks.
  task automatic test_terminal_and_halt();
    int cut;
    ending = ending_t'($urandom_range(0, 5));
    build_frame(FILL_RANDOM, {1'b0, tx_seq}, 1'($urandom_range(0, 1)));
    case (ending)
      END_LINE: begin
        cut = $urandom_range(0, FRAME_LEN - 1);
        for (int i = 0; i < cut; i++) send_word(tx_frame[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      END_FRAMING: begin
        cut = $urandom_range(0, 2);
        if (cut != 1) tx_frame[0] ^= 8'($urandom_range(1, 255));
        if (cut != 0) tx_frame[POS_END] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) tx_frame[1] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) tx_frame[POS_CSUM] ^= 8'($urandom_range(1, 255));
        send_frame();
      end
      END_IDENTITY: begin
        case ($urandom_range(0, 3))
          0: tx_frame[1] ^= 8'($urandom_range(1, 255));
          1: tx_frame[2] ^= 8'($urandom_range(1, 255));
          2: tx_frame[3] ^= 8'($urandom_range(1, 255));
          default: tx_frame[3] |= sfbd_pkg::TOP_BIT_MASK;   // product with bit 7 set
        endcase
        if ($urandom_range(0, 1)) tx_frame[POS_CSUM] ^= 8'($urandom_range(1, 255));
        send_frame();
      end
      END_CHECKSUM: begin
        if ($urandom_range(0, 1)) begin
          tx_frame[POS_SEQ] = 8'($urandom_range(0, 255));
          seal_frame();
        end
        tx_frame[POS_CSUM] ^= 8'($urandom_range(1, 255));
        send_frame();
      end
      END_SEQUENCE: begin
        if ($urandom_range(0, 1)) begin
          tx_frame[POS_SEQ] = {1'b1, tx_seq};   // bit 7 set never matches
        end else begin
          cut = $urandom_range(1, 127);
          if (cut == tx_seq) cut = (cut == 127) ? 1 : cut + 1;
          tx_frame[POS_SEQ] = 8'(cut);
        end
        seal_frame();
        send_frame();
      end
      default: begin
        tx_frame[POS_SEQ] = 8'h00;   // end of data
        seal_frame();
        send_frame();
      end
    endcase
    wait_idle();
    repeat (24) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_idle();
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_setup();
    test_config_extremes();
    test_random_frames();
    test_terminal_and_halt();

    $display("Run covered %0d frames in %0d words, %0d flash commands checked,",
             frames_sent, words_sent, cmds_checked);
    $display("sequence wrapped %0d time(s), download closed by %s, %0d mismatch(es).",
             wraps, ending.name(), mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
